/* sv/stateful_flow_firewall_unit_defines.svh */
// Assertion helpers used by the firewall top module.
`ifndef STATEFUL_FLOW_FIREWALL_UNIT_DEFINES_SVH
`define STATEFUL_FLOW_FIREWALL_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFFW_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SFFW_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error(msg);

`endif

/* sv/sffw_pkg.sv */
package sffw_pkg;

    localparam int SFFW_CAPACITY  = 64;
    localparam int SFFW_IDX_W     = 16;
    localparam int SFFW_KEY_W     = 96;
    localparam int SFFW_TIME_W    = 63;
    localparam int SFFW_TMO_W     = 40;
    localparam int SFFW_DEV_W     = 16;
    localparam int SFFW_CFG_IDX_W = 8;

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam logic [1:0] V_DROP = 2'd0;
    localparam logic [1:0] V_WAN  = 2'd1;
    localparam logic [1:0] V_LAN  = 2'd2;

    localparam logic [SFFW_CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd0;
    localparam logic [SFFW_CFG_IDX_W-1:0] CFG_LAN_DEV = 8'd1;

    // Lookup request walking down the cell row.
    typedef struct packed {
        logic                  active;
        logic                  found;
        logic [SFFW_IDX_W-1:0] found_idx;
        logic                  free;
        logic [SFFW_IDX_W-1:0] free_idx;
    } t_tok;

    // Table update broadcast to all cells after the walk.
    typedef struct packed {
        logic                  en;
        logic                  ins;
        logic [SFFW_IDX_W-1:0] idx;
    } t_wr;

endpackage

/* sv/sffw_cell.sv */
module sffw_cell #(
    parameter int IDX = 0
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sffw_pkg::t_tok                  i_tok,
    output sffw_pkg::t_tok                  o_tok,
    input  logic [sffw_pkg::SFFW_KEY_W-1:0] i_key,
    input  logic [sffw_pkg::SFFW_TIME_W-1:0] i_bound,
    input  logic [sffw_pkg::SFFW_TIME_W-1:0] i_now,
    input  sffw_pkg::t_wr                   i_wr
);
    import sffw_pkg::*;

    localparam logic [SFFW_IDX_W-1:0] MY_IDX = SFFW_IDX_W'(IDX);

    logic                   r_valid;
    logic [SFFW_KEY_W-1:0]  r_key;
    logic [SFFW_TIME_W-1:0] r_last;
    t_tok                   r_tok;
    t_tok                   n_tok;
    logic                   stale;
    logic                   live;
    logic                   hit;
    logic                   wr_me;

    assign stale = r_valid && (r_last < i_bound);
    assign live  = r_valid && !stale;
    assign hit   = live && (r_key == i_key);
    assign wr_me = i_wr.en && (i_wr.idx == MY_IDX);

    always_comb begin
        n_tok.active    = i_tok.active;
        n_tok.found     = i_tok.found | hit;
        n_tok.found_idx = i_tok.found ? i_tok.found_idx : MY_IDX;
        n_tok.free      = i_tok.free | !live;
        n_tok.free_idx  = i_tok.free ? i_tok.free_idx : MY_IDX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= n_tok.active;
            if (i_tok.active && stale) begin
                r_valid <= 1'b0;
            end else if (wr_me && i_wr.ins) begin
                r_valid <= 1'b1;
            end
        end
        r_tok.found     <= n_tok.found;
        r_tok.found_idx <= n_tok.found_idx;
        r_tok.free      <= n_tok.free;
        r_tok.free_idx  <= n_tok.free_idx;
        if (wr_me) begin
            r_last <= i_now;
            if (i_wr.ins) begin
                r_key <= i_key;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

/* sv/stateful_flow_firewall_unit.sv */
// Stateful flow firewall with idle timeout.
// Input: a header request is taken at a rising edge where i_start is high and
// o_busy is low; the fields are sampled at that edge. One request is in work
// at a time.
// Output: exactly one verdict per request, shown on o_verdict for one cycle
// with o_result_valid high (0 drop, 1 to WAN, 2 to LAN). The receiver cannot
// stall; the verdict must be taken in that cycle.
// Timing: the accepting edge loads the launch register, the lookup request then
// steps through the table cells one cell per cycle, and the result registers
// raise the strobe with the verdict. A new request can be taken in the result
// cycle, so a request is not taken before the last one has its verdict.
// Configuration: i_cfg_valid/o_cfg_ready write channel, index 0 is the
// timeout in ns, index 1 the LAN device number; o_cfg_ready is always high.
// Write only while o_busy is low.
// Reset (synchronous, i_rst_n low) empties the flow table at once and loads
// a timeout of one second and LAN device 0. No clearing pass is needed.
module stateful_flow_firewall_unit #(
    parameter int FLOW_CAPACITY = sffw_pkg::SFFW_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [15:0]                         i_device,
    input  logic [15:0]                         i_eth_type,
    input  logic [7:0]                          i_ip_protocol,
    input  logic [31:0]                         i_source_address,
    input  logic [31:0]                         i_dest_address,
    input  logic [15:0]                         i_source_port,
    input  logic [15:0]                         i_dest_port,
    input  logic [62:0]                         i_now_ns,
    output logic                                o_result_valid,
    output logic [1:0]                          o_verdict,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sffw_pkg::SFFW_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sffw_pkg::SFFW_TMO_W-1:0]     i_cfg_data
);
    import sffw_pkg::*;
    `include "stateful_flow_firewall_unit_defines.svh"

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state                 r_state;
    logic [SFFW_TMO_W-1:0]  r_timeout;
    logic [SFFW_DEV_W-1:0]  r_lan_dev;
    logic [SFFW_KEY_W-1:0]  r_key;
    logic [SFFW_TIME_W-1:0] r_bound;
    logic [SFFW_TIME_W-1:0] r_now;
    logic                   r_is_lan;
    logic                   r_ok;
    logic                   r_launch;
    t_wr                    r_wr;
    t_wr                    n_wr;
    logic                   r_res_valid;
    logic [1:0]             r_verdict;
    logic [1:0]             n_verdict;
    logic                   accept;
    logic                   is_lan;
    logic [SFFW_TIME_W-1:0] tmo_ext;
    t_tok                   w_tok [0:FLOW_CAPACITY];
    t_tok                   end_tok;

    assign accept  = i_start && !o_busy;
    assign is_lan  = (i_device == r_lan_dev);
    assign tmo_ext = SFFW_TIME_W'(r_timeout);

    assign w_tok[0] = {r_launch, ($bits(t_tok)-1)'(0)};

    for (genvar g = 0; g < FLOW_CAPACITY; g++) begin : g_cell
        sffw_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1]),
            .i_key   (r_key),
            .i_bound (r_bound),
            .i_now   (r_now),
            .i_wr    (r_wr)
        );
    end

    assign end_tok = w_tok[FLOW_CAPACITY];

    always_comb begin
        n_wr      = '0;
        n_verdict = V_DROP;
        if (end_tok.active && r_ok) begin
            if (r_is_lan) begin
                n_verdict = V_WAN;
                if (end_tok.found) begin
                    n_wr.en  = 1'b1;
                    n_wr.idx = end_tok.found_idx;
                end else if (end_tok.free) begin
                    n_wr.en  = 1'b1;
                    n_wr.ins = 1'b1;
                    n_wr.idx = end_tok.free_idx;
                end
            end else if (end_tok.found) begin
                n_verdict = V_LAN;
                n_wr.en   = 1'b1;
                n_wr.idx  = end_tok.found_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timeout   <= SFFW_TMO_W'(64'd1000000000);
            r_lan_dev   <= '0;
            r_launch    <= 1'b0;
            r_wr        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_launch    <= accept;
            r_wr        <= n_wr;
            r_res_valid <= end_tok.active;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_TIMEOUT) begin
                    r_timeout <= i_cfg_data;
                end else if (i_cfg_index == CFG_LAN_DEV) begin
                    r_lan_dev <= i_cfg_data[SFFW_DEV_W-1:0];
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (end_tok.active) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
        if (accept) begin
            r_now    <= i_now_ns;
            r_bound  <= (i_now_ns >= tmo_ext) ? (i_now_ns - tmo_ext) : '0;
            r_is_lan <= is_lan;
            r_ok     <= (i_eth_type == ETH_IPV4) &&
                        ((i_ip_protocol == PROTO_TCP) || (i_ip_protocol == PROTO_UDP));
            // WAN packets are looked up with the reverse direction key.
            r_key    <= is_lan ?
                        {i_source_address, i_dest_address, i_source_port, i_dest_port} :
                        {i_dest_address, i_source_address, i_dest_port, i_source_port};
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_verdict      = r_verdict;
    assign o_cfg_ready    = 1'b1;

    `SFFW_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, o_busy, "accept did not go busy")
    `SFFW_ASSERT_NOW(a_res_idle, i_clk, i_rst_n, o_result_valid, !o_busy, "result while busy")
    `SFFW_ASSERT_NOW(a_wr_idle, i_clk, i_rst_n, r_wr.en, !o_busy && !r_launch, "write overlaps walk")
    `SFFW_ASSERT_NOW(a_wr_res, i_clk, i_rst_n, r_wr.en, o_result_valid && (o_verdict != V_DROP), "write without forward")

endmodule

/* tb/tb_stateful_flow_firewall_unit.sv */
module tb_stateful_flow_firewall_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sffw_pkg::*;

    localparam int CAPACITY  = SFFW_CAPACITY;
    localparam int LATENCY   = CAPACITY + 2;
    localparam int POOL_MAX  = 96;

    typedef struct packed {
        logic [15:0] device;
        logic [15:0] eth_type;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [62:0] now_ns;
    } t_header;

    // Mirrors the flow table and predicts one verdict per accepted header.
    class flow_scoreboard;
        logic [95:0]       flow_keys[CAPACITY];
        bit                flow_live[CAPACITY];
        logic [63:0]       flow_seen[CAPACITY];
        logic [39:0]       timeout_ns;
        logic [15:0]       lan_device;
        logic [1:0]        verdicts_due[$];
        t_header           headers_due[$];
        int                errors;

        function new();
            timeout_ns = 40'd1000000000;
            lan_device = 16'd0;
            errors = 0;
            foreach (flow_live[i]) flow_live[i] = 0;
        endfunction

        task flag(string msg);
            $display("%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_register(logic [7:0] index, logic [39:0] data);
            if (index == CFG_TIMEOUT) timeout_ns = data;
            else if (index == CFG_LAN_DEV) lan_device = data[15:0];
        endfunction

        function int lookup(logic [95:0] k);
            for (int i = 0; i < CAPACITY; i++)
                if (flow_live[i] && flow_keys[i] == k) return i;
            return -1;
        endfunction

        function void note_request(t_header h);
            logic [63:0] now;
            logic [63:0] bound;
            logic [95:0] k;
            logic [1:0]  v;
            int          slot;
            now = {1'b0, h.now_ns};
            bound = (now >= {24'd0, timeout_ns}) ? now - {24'd0, timeout_ns} : 64'd0;
            for (int i = 0; i < CAPACITY; i++)
                if (flow_live[i] && flow_seen[i] < bound) flow_live[i] = 0;
            if (h.eth_type != ETH_IPV4 ||
                    (h.ip_protocol != PROTO_TCP && h.ip_protocol != PROTO_UDP)) begin
                v = V_DROP;
            end else if (h.device == lan_device) begin
                k = {h.source_address, h.dest_address, h.source_port, h.dest_port};
                slot = lookup(k);
                if (slot < 0) begin
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (!flow_live[i]) begin
                            slot = i;
                            break;
                        end
                    end
                    if (slot >= 0) begin
                        flow_keys[slot] = k;
                        flow_live[slot] = 1;
                    end
                end
                if (slot >= 0) flow_seen[slot] = now;
                v = V_WAN;
            end else begin
                // Replies are matched against the reversed flow.
                k = {h.dest_address, h.source_address, h.dest_port, h.source_port};
                slot = lookup(k);
                if (slot >= 0) begin
                    flow_seen[slot] = now;
                    v = V_LAN;
                end else begin
                    v = V_DROP;
                end
            end
            verdicts_due.push_back(v);
            headers_due.push_back(h);
        endfunction

        task check_verdict(logic [1:0] got);
            t_header h;
            if (verdicts_due.size() == 0) begin
                flag($sformatf("verdict %0d with no request outstanding", got));
            end else begin
                h = headers_due.pop_front();
                if (got !== verdicts_due[0])
                    flag($sformatf("verdict %0d, expected %0d (dev %h sa %h da %h t %0d)",
                        got, verdicts_due[0], h.device, h.source_address,
                        h.dest_address, h.now_ns));
                void'(verdicts_due.pop_front());
            end
        endtask

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_start = 0;
    logic        o_busy;
    logic [15:0] i_device = 0;
    logic [15:0] i_eth_type = 0;
    logic [7:0]  i_ip_protocol = 0;
    logic [31:0] i_source_address = 0;
    logic [31:0] i_dest_address = 0;
    logic [15:0] i_source_port = 0;
    logic [15:0] i_dest_port = 0;
    logic [62:0] i_now_ns = 0;
    logic        o_result_valid;
    logic [1:0]  o_verdict;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [SFFW_CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [SFFW_TMO_W-1:0]     i_cfg_data = 0;

    flow_scoreboard sb = new();

    logic [95:0] flow_pool[POOL_MAX];
    logic [62:0] clock_ns = 0;

    stateful_flow_firewall_unit dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_verdict(o_verdict);
    end

    task automatic send_header(t_header h);
        i_start <= 1'b1;
        i_device <= h.device;
        i_eth_type <= h.eth_type;
        i_ip_protocol <= h.ip_protocol;
        i_source_address <= h.source_address;
        i_dest_address <= h.dest_address;
        i_source_port <= h.source_port;
        i_dest_port <= h.dest_port;
        i_now_ns <= h.now_ns;
        do @(posedge i_clk); while (o_busy);
        sb.note_request(h);
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Drains all outstanding verdicts, then writes one register.
    task automatic write_register(logic [7:0] index, logic [39:0] data);
        i_start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(index, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_header make_header(logic [15:0] dev, logic [15:0] et,
                                            logic [7:0] pr, logic [95:0] k,
                                            logic [62:0] t);
        t_header h;
        h.device = dev;
        h.eth_type = et;
        h.ip_protocol = pr;
        {h.source_address, h.dest_address, h.source_port, h.dest_port} = k;
        h.now_ns = t;
        return h;
    endfunction

    function automatic logic [95:0] reverse_key(logic [95:0] k);
        return {k[63:32], k[95:64], k[15:0], k[31:16]};
    endfunction

    function automatic logic [95:0] random_key();
        return {$urandom, $urandom, $urandom};
    endfunction

    task automatic run_phase(logic [39:0] tmo, logic [15:0] lan, int pool_n,
                             int step_max, int count);
        t_header     h;
        logic [95:0] k;
        logic [15:0] wan;
        logic [7:0]  pr;
        int          pick;
        write_register(CFG_TIMEOUT, tmo);
        write_register(CFG_LAN_DEV, {24'd0, lan});
        for (int i = 0; i < pool_n; i++) flow_pool[i] = random_key();
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 60) == 0 && clock_ns > 63'd100)
                clock_ns = clock_ns - $urandom_range(1, 100);
            else
                clock_ns = clock_ns + $urandom_range(0, step_max);
            k = flow_pool[$urandom_range(0, pool_n - 1)];
            wan = 16'($urandom_range(0, 65535));
            if (wan == lan) wan = ~lan;
            pr = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                h = make_header(lan, ETH_IPV4, pr, k, clock_ns);
            end else if (pick < 83) begin
                h = make_header(wan, ETH_IPV4, pr, reverse_key(k), clock_ns);
            end else if (pick < 88) begin
                h = make_header(wan, ETH_IPV4, pr, random_key(), clock_ns);
            end else begin
                // Malformed headers, still able to trigger expiry.
                h = make_header($urandom_range(0, 1) ? lan : wan,
                    16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 1) ? k : reverse_key(k), clock_ns);
                if ($urandom_range(0, 1)) h.eth_type = ETH_IPV4;
                else if ($urandom_range(0, 1)) h.ip_protocol = pr;
            end
            send_header(h);
            pause_sender();
        end
    endtask

    initial begin
        logic [95:0] k;
        logic [95:0] ones;
        ones = '1;
        k = 96'h0a000001_c0a80001_1234_0050;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: protocol filtering, basic flow setup and replies.
        send_header(make_header(16'd0, 16'h86dd, PROTO_TCP, k, 63'd10));
        send_header(make_header(16'd0, ETH_IPV4, 8'd1, k, 63'd20));
        send_header(make_header(16'd0, ETH_IPV4, 8'd255, k, 63'd25));
        send_header(make_header(16'd5, ETH_IPV4, PROTO_TCP, reverse_key(k), 63'd30));
        send_header(make_header(16'd0, ETH_IPV4, PROTO_TCP, k, 63'd40));
        send_header(make_header(16'd5, ETH_IPV4, PROTO_TCP, reverse_key(k), 63'd50));
        send_header(make_header(16'd5, ETH_IPV4, PROTO_UDP, k, 63'd60));
        send_header(make_header(16'd0, ETH_IPV4, PROTO_UDP, 96'd0, 63'd70));
        send_header(make_header(16'hffff, ETH_IPV4, PROTO_UDP, 96'd0, 63'd80));
        send_header(make_header(16'd0, ETH_IPV4, PROTO_TCP, ones, 63'd90));
        send_header(make_header(16'hffff, 16'hffff, 8'hff, ones, 63'd100));
        send_header(make_header(16'hffff, ETH_IPV4, PROTO_TCP, ones, 63'd110));
        // Past the one second timeout, but no flow is stale yet: both replies refresh.
        send_header(make_header(16'd7, ETH_IPV4, PROTO_TCP, reverse_key(k), 63'd1000000041));
        send_header(make_header(16'd7, ETH_IPV4, PROTO_TCP, ones, 63'd1000000050));
        // Minimum timeout: the bound equals the last-seen time, so still alive.
        write_register(CFG_TIMEOUT, 40'd1);
        send_header(make_header(16'd3, ETH_IPV4, PROTO_UDP, ones, 63'd1000000051));
        send_header(make_header(16'd3, ETH_IPV4, PROTO_UDP, ones, 63'd1000000053));
        // Largest time stamp.
        write_register(CFG_LAN_DEV, 40'hffff);
        send_header(make_header(16'hffff, ETH_IPV4, PROTO_TCP, k, '1));
        send_header(make_header(16'd0, ETH_IPV4, PROTO_TCP, reverse_key(k), '1));
        clock_ns = 63'd2000000000;

        run_phase(40'd1000000000, 16'd0, 12, 1000, 275);
        run_phase(40'd1, 16'hffff, 6, 3, 250);
        run_phase(40'd2000, 16'($urandom_range(0, 65535)), 90, 100, 300);
        clock_ns = 63'({$urandom, $urandom} >> 2);
        run_phase(40'hff_ffff_ffff, 16'h1234, 90, 1000000, 250);
        clock_ns = clock_ns | (63'd1 << 62);
        run_phase(40'd500, 16'($urandom_range(0, 65535)), 20, 60, 275);
        run_phase({8'($urandom_range(0, 255)), $urandom}, 16'($urandom_range(0, 65535)),
                  40, $urandom_range(10, 5000), 300);

        i_start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* stateful_flow_firewall_unit.f */
+incdir+sv
sv/sffw_pkg.sv
sv/sffw_cell.sv
sv/stateful_flow_firewall_unit.sv
tb/tb_stateful_flow_firewall_unit.sv
